/* sv/a51_keystream_generator_assert.svh */
// Assertion macros used by the keystream generator top level.
`ifndef A51_KEYSTREAM_GENERATOR_ASSERT_SVH
`define A51_KEYSTREAM_GENERATOR_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define A51_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset.
`define A51_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/a51_pkg.sv */
// Types, constants and LFSR step functions for the A5/1 keystream generator.
package a51_pkg;

  localparam int R1W       = 19;
  localparam int R2W       = 22;
  localparam int R3W       = 23;
  localparam int KeyW      = 64;
  localparam int FrameW    = 22;
  localparam int ByteW     = 8;
  localparam int WarmSteps = 100;
  localparam int CntW      = 7;

  localparam logic [CntW-1:0] KEY_LAST   = CntW'(KeyW - 1);
  localparam logic [CntW-1:0] FRAME_LAST = CntW'(FrameW - 1);
  localparam logic [CntW-1:0] WARM_LAST  = CntW'(WarmSteps - 1);
  localparam logic [CntW-1:0] BYTE_LAST  = CntW'(ByteW - 1);

  typedef struct packed {
    logic              req_type;
    logic [FrameW-1:0] frame_number;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] keystream_byte;
    logic             load_done;
  } out_item_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_GEN  = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [FrameW-1:0] frame;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic finish;
  } eng_stat_t;

  function automatic logic [R1W-1:0] step_one(input logic [R1W-1:0] r);
    return {r[R1W-2:0], r[18] ^ r[17] ^ r[16] ^ r[13]};
  endfunction

  function automatic logic [R2W-1:0] step_two(input logic [R2W-1:0] r);
    return {r[R2W-2:0], r[21] ^ r[20]};
  endfunction

  function automatic logic [R3W-1:0] step_three(input logic [R3W-1:0] r);
    return {r[R3W-2:0], r[22] ^ r[21] ^ r[20] ^ r[7]};
  endfunction

endpackage

/* sv/a51_keystream_generator.sv */
// Top level of the A5/1 keystream generator: request queue, engine, assertions.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_stall   | in_data  {req_type, frame_number[21:0]}
//  out      | out_valid / out_stall | out_data {keystream_byte[7:0], load_done}
//  cfg      | cfg_valid / cfg_ready | cfg_data[63:0] = cipher_key
//
// A generate request makes one majority-clocked LFSR step per keystream bit;
// queued generates run back to back. A load runs 64 key steps, 22 frame steps
// and 100 warm-up steps. An idle engine pulls the request from the queue in
// S_IDLE before it takes its first step.
// Synchronous active-high reset clears the LFSRs, the key and the queue.
// A two-entry queue keeps taking requests while the engine works; in_stall
// rises only when it is full. A held result stalls the engine only on the
// step that would overwrite it.
module a51_keystream_generator (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  a51_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output a51_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [63:0]         cfg_data
);
  import a51_pkg::*;

  `include "a51_keystream_generator_assert.svh"

  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_pop;
  eng_stat_t eng_stat;

  // Key register is always writable; it is sampled when a load starts.
  assign cfg_ready = 1'b1;

  a51_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  a51_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .stat      (eng_stat)
  );

  // Engine never pulls from an empty queue.
  `A51_ASSERT_NOW(a_pop_nonempty, cmd_pop, cmd_valid, "command popped from empty queue")

  // A new command starts only when idle or on the finishing step.
  `A51_ASSERT_NOW(a_pop_when_free, cmd_pop, !eng_stat.busy || eng_stat.finish, "pop while busy")

  // A finishing step always loads a fresh result.
  `A51_ASSERT_NEXT(a_finish_shows, eng_stat.finish, out_valid, "finished result not presented")

  // Load acknowledgments carry a zero byte.
  `A51_ASSERT_NOW(a_load_zero, out_valid && out_data.load_done,
                  out_data.keystream_byte == 8'd0, "load result with nonzero byte")

endmodule

/* sv/a51_front.sv */
// Front end: classifies requests and queues them for the engine.
module a51_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  a51_pkg::in_item_t  in_data,
  output logic               cmd_valid,
  output a51_pkg::cmd_t      cmd,
  input  logic               cmd_pop
);
  import a51_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       new_cmd;

  assign in_stall  = (count == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];

  // Frame number only matters for a load.
  always_comb begin
    new_cmd.op    = in_data.req_type ? OP_GEN : OP_LOAD;
    new_cmd.frame = in_data.req_type ? '0 : in_data.frame_number;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, cmd_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/a51_engine.sv */
// Back end: the three LFSRs, load/warm-up/generate sequencer and result register.
module a51_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [63:0]         cfg_data,
  input  logic                cmd_valid,
  input  a51_pkg::cmd_t       cmd,
  output logic                cmd_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output a51_pkg::out_item_t  out_data,
  output a51_pkg::eng_stat_t  stat
);
  import a51_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_KEY   = 5'b00010,
    S_FRAME = 5'b00100,
    S_WARM  = 5'b01000,
    S_GEN   = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [CntW-1:0]   cnt, cnt_next;
  logic [R1W-1:0]    lfsr1, lfsr1_next;
  logic [R2W-1:0]    lfsr2, lfsr2_next;
  logic [R3W-1:0]    lfsr3, lfsr3_next;
  logic [KeyW-1:0]   cipher_key;
  logic [KeyW-1:0]   key_sh, key_sh_next;
  logic [FrameW-1:0] frame_sh, frame_sh_next;
  logic [ByteW-1:0]  byte_sh, byte_sh_next;
  logic              out_valid_next;
  out_item_t         out_data_next;

  logic              c1, c2, c3, maj, obit, mix_bit, out_free, take, finish;
  logic [R1W-1:0]    lfsr1_mj, lfsr1_mx;
  logic [R2W-1:0]    lfsr2_mj, lfsr2_mx;
  logic [R3W-1:0]    lfsr3_mj, lfsr3_mx;
  logic [ByteW-1:0]  byte_done;

  always_comb begin
    c1  = lfsr1[8];
    c2  = lfsr2[10];
    c3  = lfsr3[10];
    maj = (c1 & c2) | (c2 & c3) | (c1 & c3);
    lfsr1_mj = (c1 == maj) ? step_one(lfsr1)   : lfsr1;
    lfsr2_mj = (c2 == maj) ? step_two(lfsr2)   : lfsr2;
    lfsr3_mj = (c3 == maj) ? step_three(lfsr3) : lfsr3;
    obit = lfsr1_mj[R1W-1] ^ lfsr2_mj[R2W-1] ^ lfsr3_mj[R3W-1];
    byte_done = {obit, byte_sh[ByteW-1:1]};

    mix_bit  = (state == S_KEY) ? key_sh[0] : frame_sh[0];
    lfsr1_mx = step_one(lfsr1)   ^ {{(R1W-1){1'b0}}, mix_bit};
    lfsr2_mx = step_two(lfsr2)   ^ {{(R2W-1){1'b0}}, mix_bit};
    lfsr3_mx = step_three(lfsr3) ^ {{(R3W-1){1'b0}}, mix_bit};
  end

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    lfsr1_next     = lfsr1;
    lfsr2_next     = lfsr2;
    lfsr3_next     = lfsr3;
    key_sh_next    = key_sh;
    frame_sh_next  = frame_sh;
    byte_sh_next   = byte_sh;
    out_valid_next = out_valid && out_stall;
    out_data_next  = out_data;
    take           = 1'b0;
    finish         = 1'b0;

    case (state)
      S_IDLE: begin
        take = cmd_valid;
      end
      S_KEY: begin
        lfsr1_next  = lfsr1_mx;
        lfsr2_next  = lfsr2_mx;
        lfsr3_next  = lfsr3_mx;
        key_sh_next = key_sh >> 1;
        cnt_next    = cnt + CntW'(1);
        if (cnt == KEY_LAST) begin
          state_next = S_FRAME;
          cnt_next   = '0;
        end
      end
      S_FRAME: begin
        lfsr1_next    = lfsr1_mx;
        lfsr2_next    = lfsr2_mx;
        lfsr3_next    = lfsr3_mx;
        frame_sh_next = frame_sh >> 1;
        cnt_next      = cnt + CntW'(1);
        if (cnt == FRAME_LAST) begin
          state_next = S_WARM;
          cnt_next   = '0;
        end
      end
      S_WARM: begin
        // Last step waits for room in the result register.
        if (cnt != WARM_LAST || out_free) begin
          lfsr1_next = lfsr1_mj;
          lfsr2_next = lfsr2_mj;
          lfsr3_next = lfsr3_mj;
          cnt_next   = cnt + CntW'(1);
          if (cnt == WARM_LAST) begin
            finish                   = 1'b1;
            out_data_next.keystream_byte = '0;
            out_data_next.load_done  = 1'b1;
            state_next               = S_IDLE;
            take                     = cmd_valid;
          end
        end
      end
      S_GEN: begin
        if (cnt != BYTE_LAST || out_free) begin
          lfsr1_next   = lfsr1_mj;
          lfsr2_next   = lfsr2_mj;
          lfsr3_next   = lfsr3_mj;
          byte_sh_next = byte_done;
          cnt_next     = cnt + CntW'(1);
          if (cnt == BYTE_LAST) begin
            finish                       = 1'b1;
            out_data_next.keystream_byte = byte_done;
            out_data_next.load_done      = 1'b0;
            state_next                   = S_IDLE;
            take                         = cmd_valid;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (finish) begin
      out_valid_next = 1'b1;
    end

    // Start the next queued command right away.
    if (take) begin
      cnt_next = '0;
      if (cmd.op == OP_LOAD) begin
        lfsr1_next    = '0;
        lfsr2_next    = '0;
        lfsr3_next    = '0;
        key_sh_next   = cipher_key;
        frame_sh_next = cmd.frame;
        state_next    = S_KEY;
      end else begin
        byte_sh_next = '0;
        state_next   = S_GEN;
      end
    end
  end

  assign cmd_pop     = take;
  assign stat.busy   = (state != S_IDLE);
  assign stat.finish = finish;

  always_ff @(posedge clk) begin
    key_sh   <= key_sh_next;
    frame_sh <= frame_sh_next;
    byte_sh  <= byte_sh_next;
    cnt      <= cnt_next;
    out_data <= out_data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      lfsr1      <= '0;
      lfsr2      <= '0;
      lfsr3      <= '0;
      cipher_key <= '0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      lfsr1     <= lfsr1_next;
      lfsr2     <= lfsr2_next;
      lfsr3     <= lfsr3_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        cipher_key <= cfg_data;
      end
    end
  end

endmodule

/* tb/tb_a51_keystream_generator.sv */
// Self-checking testbench for the A5/1 keystream generator: random load/generate traffic.
module tb_a51_keystream_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import a51_pkg::*;

  // The longest correct quiet stretch is a couple of queued loads behind a long
  // output stall, so this leaves a wide margin.
  localparam int StallLimit  = 5000;
  // The drain outlasts a load in the engine; anything stray shows up by its end.
  localparam int DrainCycles = 200;
  localparam int RandPhases  = 10;
  localparam int PhaseItems  = 85;

  // ---------------------------------------------------------------------------
  // Expected-result tracker with its own copy of the three LFSRs and the key
  // ---------------------------------------------------------------------------
  class keystream_scoreboard;
    logic [R1W-1:0]  reg_a;
    logic [R2W-1:0]  reg_b;
    logic [R3W-1:0]  reg_c;
    logic [KeyW-1:0] session_key;
    out_item_t       expected_q[$];
    int              errors;

    function new();
      reg_a       = '0;
      reg_b       = '0;
      reg_c       = '0;
      session_key = '0;
      errors      = 0;
    endfunction

    // Feedback is the parity of the tapped bits, shifted in at bit 0.
    function void shift_a();
      reg_a = {reg_a[R1W-2:0], ^(reg_a & 19'h72000)};
    endfunction

    function void shift_b();
      reg_b = {reg_b[R2W-2:0], ^(reg_b & 22'h300000)};
    endfunction

    function void shift_c();
      reg_c = {reg_c[R3W-2:0], ^(reg_c & 23'h700080)};
    endfunction

    // Key and frame loading: every register moves, then the bit goes into bit 0.
    function void mix_in(logic b);
      shift_a();
      shift_b();
      shift_c();
      reg_a[0] = reg_a[0] ^ b;
      reg_b[0] = reg_b[0] ^ b;
      reg_c[0] = reg_c[0] ^ b;
    endfunction

    // Only the registers whose clocking bit agrees with the majority move.
    function void clock_majority();
      logic ca, cb, cc, vote;
      ca   = reg_a[8];
      cb   = reg_b[10];
      cc   = reg_c[10];
      vote = (ca & cb) | (cb & cc) | (ca & cc);
      if (ca == vote) shift_a();
      if (cb == vote) shift_b();
      if (cc == vote) shift_c();
    endfunction

    function void set_key(logic [KeyW-1:0] k);
      session_key = k;
    endfunction

    // Called on every accepted request; queues the one result it must produce.
    function void note_request(in_item_t req);
      out_item_t exp;
      if (req.req_type == OP_LOAD) begin
        reg_a = '0;
        reg_b = '0;
        reg_c = '0;
        for (int i = 0; i < KeyW; i++) mix_in(session_key[i]);
        for (int i = 0; i < FrameW; i++) mix_in(req.frame_number[i]);
        for (int i = 0; i < WarmSteps; i++) clock_majority();
        exp.keystream_byte = '0;
        exp.load_done      = 1'b1;
      end else begin
        for (int i = 0; i < ByteW; i++) begin
          clock_majority();
          exp.keystream_byte[i] = reg_a[R1W-1] ^ reg_b[R2W-1] ^ reg_c[R3W-1];
        end
        exp.load_done = 1'b0;
      end
      expected_q.push_back(exp);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding: byte=%02h load_done=%0b",
                 $time, got.keystream_byte, got.load_done);
        return;
      end
      exp = expected_q.pop_front();
      if (got.keystream_byte !== exp.keystream_byte) begin
        errors++;
        $display("%0t: keystream_byte mismatch: expected %02h actual %02h",
                 $time, exp.keystream_byte, got.keystream_byte);
      end
      if (got.load_done !== exp.load_done) begin
        errors++;
        $display("%0t: load_done mismatch: expected %0b actual %0b",
                 $time, exp.load_done, got.load_done);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  in_item_t        in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_item_t       out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [KeyW-1:0] cfg_data  = '0;

  // calm = no idling on either side, for back-to-back stretches
  logic            calm      = 1'b0;
  int              stall_run = 0;
  int              quiet_cycles;

  keystream_scoreboard sb;

  a51_keystream_generator u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Idle length: mostly none or a few clocks, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [FrameW-1:0] rand_frame();
    return FrameW'($urandom_range(0, 4194303));
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: random stall bursts, off while calm
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;      // hold the stall
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_run <= pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: feeds the scoreboard on every transfer, and a watchdog that ends
  // the run if no transfer of any kind happens for too long.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (cfg_valid && cfg_ready) begin
        sb.set_key(cfg_data);
        quiet_cycles = 0;
      end
      if (in_valid && !in_stall) begin
        sb.note_request(in_data);
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: watchdog: no transfer for %0d cycles", $time, StallLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving tasks
  // ---------------------------------------------------------------------------

  // One request; valid stays up after the transfer so the next one can follow
  // without a bubble.
  task automatic send_req(input op_t op, input logic [FrameW-1:0] frame);
    in_item_t req;
    int       gap;
    req.req_type     = op;
    req.frame_number = frame;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  // Every request yields a result, so an empty queue means the engine is idle.
  // The first clock lets the monitor log a transfer made at the current edge.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_key(input logic [KeyW-1:0] k);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [KeyW-1:0] key;
    sb = new();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: generate before any load must give zero bytes, frame ignored.
    calm = 1'b1;
    send_req(OP_GEN, 22'h000000);
    send_req(OP_GEN, 22'h3FFFFF);
    // Zero key and zero frame keep the registers at zero.
    send_req(OP_LOAD, 22'h000000);
    send_req(OP_GEN, 22'h000000);

    // All-ones key, all-ones frame.
    wait_idle();
    write_key({KeyW{1'b1}});
    calm = 1'b0;
    send_req(OP_LOAD, 22'h3FFFFF);
    send_req(OP_GEN, 22'h000000);
    send_req(OP_GEN, 22'h000000);
    send_req(OP_GEN, 22'h000000);

    // Key change after a load must not touch the running keystream.
    wait_idle();
    write_key(64'h0123_4567_89AB_CDEF);
    send_req(OP_GEN, 22'h000000);
    send_req(OP_LOAD, 22'h000001);
    send_req(OP_GEN, 22'h000000);
    send_req(OP_LOAD, 22'h200000);
    send_req(OP_GEN, 22'h155555);
    send_req(OP_GEN, 22'h2AAAAA);

    // Only the first and last key bits set.
    wait_idle();
    write_key(64'h8000_0000_0000_0001);
    send_req(OP_LOAD, 22'h2AAAAA);
    repeat (5) send_req(OP_GEN, 22'h000000);

    // Random phases: each writes a key, then mostly a load followed by runs
    // of generates. Odd phases start generating on the old state first.
    for (int ph = 0; ph < RandPhases; ph++) begin
      wait_idle();
      case (ph)
        0:       key = '0;
        1:       key = {KeyW{1'b1}};
        2:       key = 64'h5555_5555_5555_5555;
        3:       key = 64'hAAAA_AAAA_AAAA_AAAA;
        default: key = {$urandom, $urandom};
      endcase
      write_key(key);
      calm = (ph % 3 == 1);
      if (ph % 2 == 0) send_req(OP_LOAD, rand_frame());
      for (int n = 1; n < PhaseItems; n++) begin
        if ($urandom_range(0, 99) < 12) send_req(OP_LOAD, rand_frame());
        else send_req(OP_GEN, rand_frame());
      end
    end

    // Drain, then give the engine time to show any stray result.
    calm = 1'b0;
    wait_idle();
    repeat (DrainCycles) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/a51_pkg.sv
sv/a51_front.sv
sv/a51_engine.sv
sv/a51_keystream_generator.sv
tb/tb_a51_keystream_generator.sv
